/* sv/ildq_pkg.sv */
// ----------------------------------------------------------------------------
// ildq_pkg
// Shared types, widths and codes of the int8 linear dequantising MAC unit.
// ----------------------------------------------------------------------------
package ildq_pkg;

  localparam int unsigned ScaleW      = 32;
  localparam int unsigned RowLenW     = 13;
  localparam int unsigned OutCountW   = 11;
  localparam int unsigned OutIndexW   = 10;
  localparam int unsigned AccW        = 48;
  localparam int unsigned BiasW       = 48;
  localparam int unsigned ValueW      = 64;
  localparam int unsigned CombScaleW  = 40;
  localparam int unsigned MagW        = 32;
  localparam int unsigned MulOpW      = CombScaleW / 2;
  localparam int unsigned PartW       = MagW + MulOpW;
  localparam int unsigned ProdW       = MagW + CombScaleW;
  localparam int unsigned SumW        = ProdW + 2;
  localparam int unsigned CfgIndexW   = 2;

  localparam logic [RowLenW-1:0]   MaxInputs  = RowLenW'(4096);
  localparam logic [OutCountW-1:0] MaxOutputs = OutCountW'(1024);
  localparam logic [ScaleW-1:0]    ScaleOne   = 32'h0100_0000;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CfgIndexW-1:0] CfgInputScale = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgRowLength  = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgOutCount   = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ACC_OVF   = 2'd1,
    STATUS_BAD_SCALE = 2'd2,
    STATUS_SATURATED = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [7:0]       activation;
    logic signed [7:0]       weight;
    logic [ScaleW-1:0]       channel_scale;
    logic signed [BiasW-1:0] row_bias;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [OutIndexW-1:0]     output_index;
    status_e                  status;
    logic                     last_output;
  } out_item_t;

  typedef struct packed {
    logic signed [AccW-1:0]  acc;
    logic [ScaleW-1:0]       channel_scale;
    logic signed [BiasW-1:0] row_bias;
    logic [OutIndexW-1:0]    output_index;
    logic                    last_output;
  } row_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* sv/ildq_front.sv */
// ----------------------------------------------------------------------------
// ildq_front
// Accumulates activation-weight products and hands each finished row to the
// row queue with its bias, channel scale and output index.
// ----------------------------------------------------------------------------
module ildq_front
  import ildq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [RowLenW-1:0]   row_length_i,
  input  logic [OutCountW-1:0] output_count_i,
  input  logic                 accept_i,
  input  in_item_t             item_i,
  output logic                 push_o,
  output row_job_t             job_o
);

  logic signed [AccW-1:0] acc_q, acc_d;
  logic [RowLenW-1:0]     elem_cnt_q, elem_cnt_d;
  logic [OutIndexW-1:0]   out_cnt_q, out_cnt_d;

  logic signed [15:0]     product;
  logic signed [AccW-1:0] acc_sum;
  logic [RowLenW-1:0]     eff_len;
  logic [OutCountW-1:0]   eff_cnt;
  logic [RowLenW-1:0]     elem_next;
  logic [OutCountW-1:0]   out_next;
  logic                   row_end;
  logic                   last_row;

  always_comb begin
    if (row_length_i == '0) begin
      eff_len = RowLenW'(1);
    end else if (row_length_i > MaxInputs) begin
      eff_len = MaxInputs;
    end else begin
      eff_len = row_length_i;
    end
    if (output_count_i == '0) begin
      eff_cnt = OutCountW'(1);
    end else if (output_count_i > MaxOutputs) begin
      eff_cnt = MaxOutputs;
    end else begin
      eff_cnt = output_count_i;
    end
  end

  assign product   = item_i.activation * item_i.weight;
  assign acc_sum   = acc_q + AccW'(product);
  assign elem_next = elem_cnt_q + RowLenW'(1);
  assign row_end   = elem_next >= eff_len;
  assign out_next  = OutCountW'(out_cnt_q) + OutCountW'(1);
  assign last_row  = out_next >= eff_cnt;

  always_comb begin
    acc_d      = acc_q;
    elem_cnt_d = elem_cnt_q;
    out_cnt_d  = out_cnt_q;
    if (accept_i) begin
      if (row_end) begin
        acc_d      = '0;
        elem_cnt_d = '0;
        out_cnt_d  = last_row ? '0 : out_next[OutIndexW-1:0];
      end else begin
        acc_d      = acc_sum;
        elem_cnt_d = elem_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      elem_cnt_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      acc_q      <= acc_d;
      elem_cnt_q <= elem_cnt_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  assign push_o              = accept_i && row_end;
  assign job_o.acc           = acc_sum;
  assign job_o.channel_scale = item_i.channel_scale;
  assign job_o.row_bias      = item_i.row_bias;
  assign job_o.output_index  = out_cnt_q;
  assign job_o.last_output   = last_row;

endmodule

/* sv/ildq_queue.sv */
// ----------------------------------------------------------------------------
// ildq_queue
// Short register queue of finished rows between the accumulating front end
// and the scaling back end.
// ----------------------------------------------------------------------------
module ildq_queue
  import ildq_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  row_job_t      job_i,
  input  logic          pop_i,
  output row_job_t      job_o,
  output queue_status_t status_o
);

  row_job_t             entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QueuePtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QueuePtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QueueCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o          = entries_q[rd_ptr_q];
  assign status_o.full  = count_q == QueueCntW'(QueueDepth);
  assign status_o.empty = count_q == '0;

endmodule

/* sv/ildq_back.sv */
// ----------------------------------------------------------------------------
// ildq_back
// Forms the rounded combined scale, multiplies the row sum by it on a shared
// 32x20 multiplier, adds the bias, saturates and fills the output register.
// ----------------------------------------------------------------------------
module ildq_back
  import ildq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ScaleW-1:0] input_scale_i,
  input  row_job_t          job_i,
  input  queue_status_t     queue_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StScale   = 3'd1;
  localparam logic [2:0] StMulLo   = 3'd2;
  localparam logic [2:0] StMulHi   = 3'd3;
  localparam logic [2:0] StCombine = 3'd4;
  localparam logic [2:0] StFinish  = 3'd5;

  localparam logic [63:0]        RoundHalf = 64'h0000_0000_0080_0000;
  localparam logic [ValueW-1:0]  ValueMax  = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic [ValueW-1:0]  ValueMin  = {1'b1, {(ValueW-1){1'b0}}};

  logic [2:0]            state_q, state_d;
  row_job_t              job_q;
  logic [CombScaleW-1:0] scale_q;
  logic [MagW-1:0]       mag_q;
  logic                  neg_q;
  logic                  acc_ovf_q;
  logic [PartW-1:0]      lo_q;
  logic [PartW-1:0]      hi_q;
  logic [ProdW-1:0]      prod_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic [63:0]            scale_full;
  logic [AccW-1:0]        acc_neg;
  logic [MulOpW-1:0]      mul_op;
  logic [PartW-1:0]       part;
  logic signed [SumW-1:0] bias_ext;
  logic signed [SumW-1:0] prod_ext;
  logic signed [SumW-1:0] sum;
  logic                   sum_out_of_range;
  logic                   out_free;
  out_item_t              result;

  assign scale_full = 64'(input_scale_i) * 64'(job_q.channel_scale) + RoundHalf;
  assign acc_neg    = AccW'(-job_q.acc);
  assign mul_op     = (state_q == StMulLo) ? scale_q[MulOpW-1:0]
                                           : scale_q[CombScaleW-1:MulOpW];
  assign part       = PartW'(mag_q) * PartW'(mul_op);

  assign bias_ext = SumW'(job_q.row_bias);
  assign prod_ext = $signed({2'b00, prod_q});
  assign sum      = neg_q ? (bias_ext - prod_ext) : (bias_ext + prod_ext);
  assign sum_out_of_range = sum[SumW-1:ValueW-1] != {(SumW-ValueW+1){sum[SumW-1]}};

  always_comb begin
    result.output_index = job_q.output_index;
    result.last_output  = job_q.last_output;
    if (acc_ovf_q) begin
      result.status = STATUS_ACC_OVF;
      result.value  = '0;
    end else if (scale_q == '0) begin
      result.status = STATUS_BAD_SCALE;
      result.value  = '0;
    end else if (sum_out_of_range) begin
      result.status = STATUS_SATURATED;
      result.value  = sum[SumW-1] ? ValueMin : ValueMax;
    end else begin
      result.status = STATUS_OK;
      result.value  = sum[ValueW-1:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == StIdle) && !queue_i.empty;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (!queue_i.empty) begin
          state_d = StScale;
        end
      end
      StScale:   state_d = StMulLo;
      StMulLo:   state_d = StMulHi;
      StMulHi:   state_d = StCombine;
      StCombine: state_d = StFinish;
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StFinish && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == StScale) begin
      scale_q   <= scale_full[63:24];
      neg_q     <= job_q.acc[AccW-1];
      mag_q     <= job_q.acc[AccW-1] ? acc_neg[MagW-1:0] : job_q.acc[MagW-1:0];
      acc_ovf_q <= job_q.acc[AccW-1:31] != {(AccW-31){job_q.acc[AccW-1]}};
    end
    if (state_q == StMulLo) begin
      lo_q <= part;
    end
    if (state_q == StMulHi) begin
      hi_q <= part;
    end
    if (state_q == StCombine) begin
      prod_q <= ProdW'(lo_q) + {hi_q, {MulOpW{1'b0}}};
    end
    if (state_q == StFinish && out_free) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !queue_i.empty)
    else $error("Row taken from an empty queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish && out_valid_q && out_stall_i) |=> (state_q == StFinish))
    else $error("Back end left the final step while the output was blocked.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == STATUS_ACC_OVF || out_q.status == STATUS_BAD_SCALE))
      |-> (out_q.value == '0))
    else $error("Non-zero value on an overflow or invalid-scale result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == STATUS_SATURATED)
      |-> (out_q.value == ValueMax || out_q.value == ValueMin))
    else $error("Saturated result does not hold a limit value.");

endmodule

/* sv/int8_linear_dequant_mac_unit.sv */
// ----------------------------------------------------------------------------
// int8_linear_dequant_mac_unit
// Quantised int8 linear layer with per-channel scale and Q39.24 output.
// ----------------------------------------------------------------------------
// The front end takes one activation and weight word per cycle while the
// input is not stalled and adds their product to the row sum. Each finished
// row enters a four-entry queue. The back end takes one row at a time, in
// order: queue read, combined scale, two passes through one shared 32x20
// multiplier, product assembly, bias add and saturation; it reads the next
// row only after the last step, which waits while the output is stalled.
// Input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module int8_linear_dequant_mac_unit
  import ildq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [ScaleW-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  logic [ScaleW-1:0]    input_scale_q;
  logic [RowLenW-1:0]   row_length_q;
  logic [OutCountW-1:0] output_count_q;

  logic          cfg_write;
  logic          in_accept;
  logic          push;
  logic          pop;
  row_job_t      push_job;
  row_job_t      head_job;
  queue_status_t queue_status;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_scale_q  <= ScaleOne;
      row_length_q   <= RowLenW'(1);
      output_count_q <= OutCountW'(1);
    end else if (cfg_write) begin
      case (cfg_index_i)
        CfgInputScale: input_scale_q  <= cfg_data_i;
        CfgRowLength:  row_length_q   <= cfg_data_i[RowLenW-1:0];
        CfgOutCount:   output_count_q <= cfg_data_i[OutCountW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = queue_status.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  ildq_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_length_i   (row_length_q),
    .output_count_i (output_count_q),
    .accept_i       (in_accept),
    .item_i         (in_item_i),
    .push_o         (push),
    .job_o          (push_job)
  );

  ildq_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (queue_status)
  );

  ildq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .input_scale_i (input_scale_q),
    .job_i         (head_job),
    .queue_i       (queue_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

endmodule
